FILE: hdl/rgbhsv_pkg.sv
package rgbhsv_pkg;

  localparam int CHANNEL_BITS      = 8;
  localparam int HUE_FRACTION_BITS = 8;

  // hue is 0 to under 6 sectors: three integer bits above the fraction
  localparam int HUE_BITS  = HUE_FRACTION_BITS + 3;
  // hue numerator is below 6 * chroma
  localparam int NUM_BITS  = CHANNEL_BITS + 3;
  localparam int HDIV_BITS = NUM_BITS + HUE_FRACTION_BITS;
  localparam int SDIV_BITS = 2 * CHANNEL_BITS;
  localparam int STAGES    = (HUE_BITS > CHANNEL_BITS) ? HUE_BITS : CHANNEL_BITS;

  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

  typedef logic [CHANNEL_BITS-1:0] chan_t;

  // classified pixel, ready for the two divisions
  typedef struct packed {
    logic [HDIV_BITS-1:0] hue_div;
    logic [SDIV_BITS-1:0] sat_div;
    chan_t                chroma;
    chan_t                vmax;
    logic                 gray;
  } job_t;

  typedef struct packed {
    logic valid;
    job_t job;
  } job_slot_t;

  // one stage of the divider pipeline
  typedef struct packed {
    chan_t               hue_rem;
    logic [HUE_BITS-1:0] hue_acc;
    chan_t               sat_rem;
    chan_t               sat_acc;
    chan_t               chroma;
    chan_t               vmax;
    logic                gray;
  } stage_t;

  // one restoring division step: returns {quotient bit, new remainder}
  function automatic logic [CHANNEL_BITS:0] div_bit(chan_t rem, logic din, chan_t dvs);
    logic [CHANNEL_BITS:0] trial;
    logic [CHANNEL_BITS:0] diff;
    trial = {rem, din};
    diff  = trial - {1'b0, dvs};
    if (trial >= {1'b0, dvs}) begin
      div_bit = {1'b1, diff[CHANNEL_BITS-1:0]};
    end else begin
      div_bit = {1'b0, trial[CHANNEL_BITS-1:0]};
    end
  endfunction

endpackage

FILE: hdl/rgbhsv_front.sv
module rgbhsv_front
  import rgbhsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  output logic      full,
  input  chan_t     red,
  input  chan_t     green,
  input  chan_t     blue,
  input  logic      q_full,
  output job_slot_t q_in
);

  logic  fv;
  job_t  job;
  job_t  job_next;
  logic  load;

  logic                r_max;
  logic                g_max;
  chan_t               vmax;
  chan_t               vmin;
  chan_t               chroma;
  logic [NUM_BITS-1:0] c_ext;
  logic [NUM_BITS-1:0] six_c;
  logic [NUM_BITS-1:0] num;

  always_comb begin
    r_max = (red >= green) && (red >= blue);
    g_max = !r_max && (green >= blue);
    if (r_max) begin
      vmax = red;
    end else if (g_max) begin
      vmax = green;
    end else begin
      vmax = blue;
    end
    vmin = red;
    if (green < vmin) vmin = green;
    if (blue < vmin) vmin = blue;
    chroma = vmax - vmin;
    c_ext  = {3'b000, chroma};
    six_c  = (c_ext << 2) + (c_ext << 1);

    // red sector wraps into the sixth sector when green is below blue
    if (r_max) begin
      if (green >= blue) begin
        num = {3'b000, green} - {3'b000, blue};
      end else begin
        num = six_c - ({3'b000, blue} - {3'b000, green});
      end
    end else if (g_max) begin
      num = (c_ext << 1) + {3'b000, blue} - {3'b000, red};
    end else begin
      num = (c_ext << 2) + {3'b000, red} - {3'b000, green};
    end

    job_next.hue_div = {num, {HUE_FRACTION_BITS{1'b0}}};
    job_next.sat_div = {chroma, {CHANNEL_BITS{1'b0}}} - {{CHANNEL_BITS{1'b0}}, chroma};
    job_next.chroma  = chroma;
    job_next.vmax    = vmax;
    job_next.gray    = (chroma == '0);
  end

  assign load       = !fv || !q_full;
  assign full       = !load;
  assign q_in.valid = fv;
  assign q_in.job   = job;

  always_ff @(posedge clk) begin
    if (rst) begin
      fv <= 1'b0;
    end else if (load) begin
      fv <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (load && push) begin
      job <= job_next;
    end
  end

endmodule

FILE: hdl/rgbhsv_queue.sv
module rgbhsv_queue
  import rgbhsv_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  job_slot_t q_in,
  output logic      q_full,
  output job_slot_t q_out,
  input  logic      q_pop
);

  job_t                 slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr;
  logic [QPTR_BITS-1:0] rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push;
  logic                 do_pop;

  assign q_full      = (count == (QPTR_BITS+1)'(QUEUE_DEPTH));
  assign q_out.valid = (count != '0);
  assign q_out.job   = slots[rd_ptr];
  assign do_push     = q_in.valid && !q_full;
  assign do_pop      = q_pop && q_out.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_BITS'(QUEUE_DEPTH-1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= q_in.job;
    end
  end

endmodule

FILE: hdl/rgbhsv_back.sv
module rgbhsv_back
  import rgbhsv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  job_slot_t           q_out,
  output logic                q_pop,
  output logic                empty,
  input  logic                pop,
  output logic [HUE_BITS-1:0] hue,
  output chan_t               saturation,
  output chan_t               brightness
);

  stage_t st  [STAGES];
  logic   sv  [STAGES];
  stage_t src [STAGES];
  stage_t nxt [STAGES];
  logic   adv;

  logic [CHANNEL_BITS:0] hres;
  logic [CHANNEL_BITS:0] sres;

  // whole pipeline moves unless the finished item is stuck at the output
  assign adv   = !sv[STAGES-1] || pop;
  assign q_pop = adv && q_out.valid;

  always_comb begin
    hres = '0;
    sres = '0;
    src[0].hue_rem = q_out.job.hue_div[HDIV_BITS-1:HUE_BITS];
    src[0].hue_acc = q_out.job.hue_div[HUE_BITS-1:0];
    src[0].sat_rem = q_out.job.sat_div[SDIV_BITS-1:CHANNEL_BITS];
    src[0].sat_acc = q_out.job.sat_div[CHANNEL_BITS-1:0];
    src[0].chroma  = q_out.job.chroma;
    src[0].vmax    = q_out.job.vmax;
    src[0].gray    = q_out.job.gray;
    for (int k = 1; k < STAGES; k++) begin
      src[k] = st[k-1];
    end
    for (int k = 0; k < STAGES; k++) begin
      nxt[k] = src[k];
      if (k < HUE_BITS) begin
        hres = div_bit(src[k].hue_rem, src[k].hue_acc[HUE_BITS-1], src[k].chroma);
        nxt[k].hue_rem = hres[CHANNEL_BITS-1:0];
        nxt[k].hue_acc = {src[k].hue_acc[HUE_BITS-2:0], hres[CHANNEL_BITS]};
      end
      if (k < CHANNEL_BITS) begin
        sres = div_bit(src[k].sat_rem, src[k].sat_acc[CHANNEL_BITS-1], src[k].vmax);
        nxt[k].sat_rem = sres[CHANNEL_BITS-1:0];
        nxt[k].sat_acc = {src[k].sat_acc[CHANNEL_BITS-2:0], sres[CHANNEL_BITS]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < STAGES; k++) begin
        sv[k] <= 1'b0;
      end
    end else if (adv) begin
      sv[0] <= q_out.valid;
      for (int k = 1; k < STAGES; k++) begin
        sv[k] <= sv[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int k = 0; k < STAGES; k++) begin
        st[k] <= nxt[k];
      end
    end
  end

  // grey and black pixels carry no hue or saturation
  assign empty      = !sv[STAGES-1];
  assign hue        = st[STAGES-1].gray ? '0 : st[STAGES-1].hue_acc;
  assign saturation = st[STAGES-1].gray ? '0 : st[STAGES-1].sat_acc;
  assign brightness = st[STAGES-1].vmax;

endmodule

FILE: hdl/rgb_to_hsv_convert_top.sv
// Channel   Handshake          Payload
// pixel     push / full        red, green, blue
// result    empty / pop        hue, saturation, brightness
//
// One pixel per clock sustained while results are popped. A pixel passes
// through the classify register, the 4-entry queue and the divider pipeline,
// which yields one hue quotient bit per stage and one saturation bit in each of
// the first 8 stages.
// Reset clears all valid flags, queue pointers and the queue count; nothing else is cleared.
// A waiting result holds the divider pipeline; the queue and the classify
// register then take up to five more pixels before full rises.
module rgb_to_hsv_convert_top
  import rgbhsv_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  chan_t               red,
  input  chan_t               green,
  input  chan_t               blue,
  output logic                empty,
  input  logic                pop,
  output logic [HUE_BITS-1:0] hue,
  output chan_t               saturation,
  output chan_t               brightness
);

  job_slot_t q_in;
  job_slot_t q_out;
  logic      q_full;
  logic      q_pop;

  rgbhsv_front u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .red    (red),
    .green  (green),
    .blue   (blue),
    .q_full (q_full),
    .q_in   (q_in)
  );

  rgbhsv_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .q_in   (q_in),
    .q_full (q_full),
    .q_out  (q_out),
    .q_pop  (q_pop)
  );

  rgbhsv_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_out      (q_out),
    .q_pop      (q_pop),
    .empty      (empty),
    .pop        (pop),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness)
  );

endmodule
